// ----- design/dqpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque with positional edit: shared package
// Command and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package dqpe_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_HEAD = 3'd0,
    CMD_PUSH_TAIL = 3'd1,
    CMD_POP_HEAD  = 3'd2,
    CMD_POP_TAIL  = 3'd3,
    CMD_EDIT_HEAD = 3'd4,
    CMD_EDIT_TAIL = 3'd5,
    CMD_EDIT_POS  = 3'd6,
    CMD_QUERY     = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

endpackage

// ----- design/deque_with_positional_edit_unit.sv -----
// ----------------------------------------------------------------------------
// Deque with positional edit
// The result word appears in the cycle after the command is accepted.
// Throughput: one command per cycle; each command makes at most one access to
// the entry RAM and updates the head index and entry count in the same cycle.
// Reset: head index, entry count and the result strobe clear; RAM contents
// stay undefined until pushed.
// ----------------------------------------------------------------------------
module deque_with_positional_edit_unit #(
  parameter int DEPTH      = dqpe_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqpe_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dqpe_pkg::CMD_W-1:0]   in_command,
  input  logic [dqpe_pkg::VALUE_W-1:0] in_value,
  input  logic [dqpe_pkg::POS_W-1:0]   in_position,
  output logic                         out_valid,
  output logic [dqpe_pkg::VALUE_W-1:0] out_value_out,
  output logic [dqpe_pkg::STAT_W-1:0]  out_status,
  output logic [dqpe_pkg::FILL_W-1:0]  out_fill_count,
  output logic                         out_empty_flag
);

  import dqpe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r;
  status_t               status_r, status_nxt;
  logic [FILL_W-1:0]     fill_r;
  logic                  empty_r;
  logic                  pop_r, pop_nxt;

  cmd_t                  cmd;
  logic                  accept;
  logic                  is_full, no_entries, pos_bad;
  logic [AW-1:0]         head_dec, head_inc, tail_idx, push_tail_idx, pos_idx;
  logic [AW-1:0]         ram_addr;
  logic                  ram_we, ram_re;
  logic [63:0]           value_ext, rdata_ext;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [POS_W-1:0]      pos_m1;
  logic [15:0]           count_ext;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign cmd       = cmd_t'(in_command);
  assign value_ext = 64'(in_value);
  assign ram_wdata = value_ext[DATA_WIDTH-1:0];
  assign count_ext = 16'(count_r);

  assign is_full    = (count_r == CW'(DEPTH));
  assign no_entries = (count_r == '0);
  assign pos_bad    = (in_position == '0) || (16'(in_position) > count_ext);
  assign pos_m1     = in_position - POS_W'(1);

  assign head_dec      = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc      = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_idx      = ring_add(head_r, count_r - CW'(1));
  assign push_tail_idx = ring_add(head_r, count_r);
  assign pos_idx       = ring_add(head_r, CW'(pos_m1));

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    ram_addr   = head_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    status_nxt = ST_OK;
    pop_nxt    = 1'b0;
    unique case (cmd)
      CMD_PUSH_HEAD: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          head_nxt  = head_dec;
          ram_addr  = head_dec;
          ram_we    = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_PUSH_TAIL: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_addr  = push_tail_idx;
          ram_we    = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_POP_HEAD: begin
        if (no_entries) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re    = accept;
          pop_nxt   = 1'b1;
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_POP_TAIL: begin
        if (no_entries) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_addr  = tail_idx;
          ram_re    = accept;
          pop_nxt   = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_EDIT_HEAD: begin
        if (no_entries) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_we = accept;
        end
      end
      CMD_EDIT_TAIL: begin
        if (no_entries) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_addr = tail_idx;
          ram_we   = accept;
        end
      end
      CMD_EDIT_POS: begin
        if (no_entries) begin
          status_nxt = ST_EMPTY;
        end else if (pos_bad) begin
          status_nxt = ST_BADPOS;
        end else begin
          ram_addr = pos_idx;
          ram_we   = accept;
        end
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  dqpe_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pop_r    <= pop_nxt;
      fill_r   <= FILL_W'(16'(count_nxt));
      empty_r  <= (count_nxt == '0);
    end
  end

  assign rdata_ext      = 64'(ram_rdata);
  assign out_valid      = out_valid_r;
  assign out_value_out  = pop_r ? rdata_ext[VALUE_W-1:0] : '0;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;
  assign out_empty_flag = empty_r;

`ifndef NO_ASSERTIONS
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy && rst_n))
    else $error("result strobe does not follow an accepted command");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_value_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_out != '0) |-> (out_status == ST_OK))
    else $error("nonzero word on a refused command");

  a_full_only_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      ($past(in_command) == CMD_PUSH_HEAD || $past(in_command) == CMD_PUSH_TAIL))
    else $error("full status on a command other than a push");
`endif

endmodule

// ----- design/dqpe_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for deque_with_positional_edit_unit
// Commands are queued up front and sent through the start/busy handshake by
// a clocked driver. The driver keeps a shadow ring of the deque and works out
// the result word of every accepted command. A clocked monitor compares each
// strobed result with the oldest one awaited. The stimulus runs a short
// directed pass over the empty, full and bad position cases, then random
// fill and drain runs under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;
  import dqpe_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int RAND_PER_PHASE = 150;

  typedef struct {
    cmd_t            command;
    logic [31:0]     value;
    logic [4:0]      position;
    int unsigned     idle_pct;
  } deque_cmd_t;

  typedef struct {
    logic [31:0]     word;
    status_t         status;
    logic [4:0]      fill;
    logic            empty;
  } deque_word_t;

  logic        clk;
  logic        rst_n;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_command = CMD_QUERY;
  logic [31:0] in_value = '0;
  logic [4:0]  in_position = '0;
  logic        out_valid;
  logic [31:0] out_value_out;
  logic [1:0]  out_status;
  logic [4:0]  out_fill_count;
  logic        out_empty_flag;

  deque_cmd_t  pending_cmds[$];
  deque_word_t awaited_words[$];
  deque_cmd_t  cmd_on_port;
  int          issued_count = 0;
  int          total_cmds = 0;
  int          error_count = 0;
  int          gen_fill = 0;

  logic [31:0] shadow_ring[RING_DEPTH];
  logic [3:0]  shadow_head = '0;
  logic [4:0]  shadow_count = '0;

  deque_with_positional_edit_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .out_empty_flag (out_empty_flag)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic note_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic apply_deque_cmd(input deque_cmd_t c, output deque_word_t r);
    logic [3:0] tail;
    tail = shadow_head + shadow_count[3:0] - 4'd1;
    r.word = '0;
    r.status = ST_OK;
    case (c.command)
      CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
        if (shadow_count == 5'(RING_DEPTH)) begin
          r.status = ST_FULL;
        end else if (c.command == CMD_PUSH_HEAD) begin
          shadow_head = shadow_head - 4'd1;
          shadow_ring[shadow_head] = c.value;
          shadow_count++;
        end else begin
          shadow_ring[shadow_head + shadow_count[3:0]] = c.value;
          shadow_count++;
        end
      end
      CMD_POP_HEAD: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = shadow_ring[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count--;
        end
      end
      CMD_POP_TAIL: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = shadow_ring[tail];
          shadow_count--;
        end
      end
      CMD_EDIT_HEAD: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_ring[shadow_head] = c.value;
      end
      CMD_EDIT_TAIL: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_ring[tail] = c.value;
      end
      CMD_EDIT_POS: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (c.position == 0 || c.position > shadow_count) r.status = ST_BADPOS;
        else shadow_ring[shadow_head + 4'(c.position - 5'd1)] = c.value;
      end
      default: begin
      end
    endcase
    r.fill = shadow_count;
    r.empty = (shadow_count == 0);
  endtask

  always @(posedge clk) begin
    deque_word_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_deque_cmd(cmd_on_port, r);
        awaited_words.push_back(r);
        issued_count++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
          cmd_on_port = pending_cmds.pop_front();
          in_command <= cmd_on_port.command;
          in_value <= cmd_on_port.value;
          in_position <= cmd_on_port.position;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    deque_word_t e;
    if (rst_n && out_valid !== 1'b0) begin
      if (awaited_words.size() == 0) begin
        note_mismatch("result word with none awaited");
      end else begin
        e = awaited_words.pop_front();
        if (out_value_out !== e.word)
          note_mismatch($sformatf("value_out %h, want %h", out_value_out, e.word));
        if (out_status !== e.status)
          note_mismatch($sformatf("status %0d, want %s", out_status, e.status.name()));
        if (out_fill_count !== e.fill)
          note_mismatch($sformatf("fill_count %0d, want %0d", out_fill_count, e.fill));
        if (out_empty_flag !== e.empty)
          note_mismatch($sformatf("empty_flag %b, want %b", out_empty_flag, e.empty));
      end
    end
  end

  task automatic add_cmd(input cmd_t c, input logic [31:0] v, input logic [4:0] p,
                         input int unsigned idle);
    deque_cmd_t item;
    item.command = c;
    item.value = v;
    item.position = p;
    item.idle_pct = idle;
    pending_cmds.push_back(item);
    total_cmds++;
    if ((c == CMD_PUSH_HEAD || c == CMD_PUSH_TAIL) && gen_fill < RING_DEPTH) gen_fill++;
    if ((c == CMD_POP_HEAD || c == CMD_POP_TAIL) && gen_fill > 0) gen_fill--;
  endtask

  task automatic add_random_cmd(input bit fill_bias, input int unsigned idle);
    int unsigned roll;
    cmd_t c;
    logic [31:0] v;
    logic [4:0] p;
    roll = $urandom_range(99);
    if (roll < 55) c = fill_bias ? cmd_t'($urandom_range(0, 1)) : cmd_t'($urandom_range(2, 3));
    else if (roll < 70) c = fill_bias ? cmd_t'($urandom_range(2, 3)) : cmd_t'($urandom_range(0, 1));
    else c = cmd_t'($urandom_range(4, 7));
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    if (c == CMD_EDIT_POS && $urandom_range(99) < 75)
      p = 5'($urandom_range(1, gen_fill > 0 ? gen_fill : 1));
    else
      p = 5'($urandom_range(0, 31));
    add_cmd(c, v, p, idle);
  endtask

  initial begin
    int unsigned idle_rates[4];
    int unsigned left_in_run;
    bit fill_bias;
    idle_rates = '{0, 63, 0, 38};

    add_cmd(CMD_QUERY, 32'h0, 5'd0, 0);
    add_cmd(CMD_POP_HEAD, 32'h0, 5'd0, 0);
    add_cmd(CMD_POP_TAIL, 32'h0, 5'd31, 0);
    add_cmd(CMD_EDIT_HEAD, 32'h1234_5678, 5'd1, 0);
    add_cmd(CMD_EDIT_TAIL, 32'h8765_4321, 5'd1, 0);
    add_cmd(CMD_EDIT_POS, 32'hDEAD_BEEF, 5'd1, 0);
    add_cmd(CMD_PUSH_TAIL, 32'hFFFF_FFFF, 5'd0, 0);
    add_cmd(CMD_PUSH_HEAD, 32'h0000_0000, 5'd0, 0);
    add_cmd(CMD_EDIT_POS, 32'hA5A5_A5A5, 5'd0, 0);
    add_cmd(CMD_EDIT_POS, 32'h5A5A_5A5A, 5'd3, 0);
    add_cmd(CMD_EDIT_POS, 32'hAAAA_5555, 5'd2, 0);
    for (int i = 0; i < 14; i++)
      add_cmd(i % 2 ? CMD_PUSH_HEAD : CMD_PUSH_TAIL, $urandom, 5'd0, 0);
    add_cmd(CMD_PUSH_HEAD, 32'hFFFF_FFFF, 5'd0, 0);
    add_cmd(CMD_PUSH_TAIL, 32'hFFFF_FFFF, 5'd0, 0);
    add_cmd(CMD_EDIT_POS, 32'h5555_AAAA, 5'd16, 0);
    add_cmd(CMD_EDIT_POS, 32'h5555_AAAA, 5'd17, 0);

    fill_bias = 1'b0;
    left_in_run = 0;
    foreach (idle_rates[ph]) begin
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (left_in_run == 0) begin
          fill_bias = ~fill_bias;
          left_in_run = $urandom_range(20, 40);
        end
        left_in_run--;
        add_random_cmd(fill_bias, idle_rates[ph]);
      end
    end

    while (issued_count < total_cmds) @(posedge clk);
    while (awaited_words.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("deque_with_positional_edit_unit: match");
    end else begin
      $display("deque_with_positional_edit_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("deque_with_positional_edit_unit: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
design/dqpe_pkg.sv
design/dqpe_ram.sv
design/deque_with_positional_edit_unit.sv
tb/sv/tb.sv
